>>> rtl/core/hsed_pkg.sv
// package: widths, masks and types shared by the hamming sec encode/decode files
package hsed_pkg;

    localparam int DATA_BITS  = 32;
    localparam int CHECK_BITS = 6;
    localparam int NUM_ROWS   = 6;

    localparam int DATA_W  = 32;
    localparam int CHECK_W = 6;
    localparam int ROW_W   = 32;
    localparam int CFG_IDX_W = $clog2(NUM_ROWS);

    localparam logic [DATA_W-1:0] DATA_MASK = (DATA_BITS >= DATA_W) ? {DATA_W{1'b1}} :
        DATA_W'((64'd1 << DATA_BITS) - 64'd1);
    localparam logic [CHECK_W-1:0] CHECK_MASK = (CHECK_BITS >= CHECK_W) ? {CHECK_W{1'b1}} :
        CHECK_W'((64'd1 << CHECK_BITS) - 64'd1);

    typedef enum logic {
        ACT_ENCODE = 1'b0,
        ACT_DECODE = 1'b1
    } t_action;

    typedef logic [DATA_W-1:0]  t_data;
    typedef logic [CHECK_W-1:0] t_check;
    typedef logic [ROW_W-1:0]   t_row;

endpackage

>>> rtl/core/hsed_req_if.sv
// interface: request channel into the encode/decode unit
interface hsed_req_if;
    logic                  valid;
    logic                  ready;
    hsed_pkg::t_action     action;
    hsed_pkg::t_data       data_bits;
    hsed_pkg::t_check      check_bits;

    modport source (output valid, output action, output data_bits, output check_bits,
                    input ready);
    modport sink   (input valid, input action, input data_bits, input check_bits,
                    output ready);
endinterface

>>> rtl/core/hsed_rsp_if.sv
// interface: result channel out of the encode/decode unit
interface hsed_rsp_if;
    logic              valid;
    logic              ready;
    hsed_pkg::t_data   data_out;
    hsed_pkg::t_check  check_out;
    logic              corrected;

    modport source (output valid, output data_out, output check_out, output corrected,
                    input ready);
    modport sink   (input valid, input data_out, input check_out, input corrected,
                    output ready);
endinterface

>>> rtl/core/hamming_sec_encode_decode_unit.sv
// top level: sec hamming encoder and decoder with configurable parity matrix
// path: request accept, then the input register, then the result register, then result valid
// throughput: one request per cycle while results are taken; the request side takes a new request while a
// result waits, as long as the input register is free or moves on in that cycle
// reset: synchronous active low; clears both valid flags and all parity rows to zero
module hamming_sec_encode_decode_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [hsed_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  hsed_pkg::t_row                       i_cfg_wdata,
    hsed_req_if.sink                             i_req,
    hsed_rsp_if.source                           o_rsp
);

    hsed_pkg::t_row    r_rows [hsed_pkg::NUM_ROWS];

    logic              r_s1_valid;
    hsed_pkg::t_action r_s1_action;
    hsed_pkg::t_data   r_s1_data;
    hsed_pkg::t_check  r_s1_check;

    logic              r_out_valid;
    hsed_pkg::t_data   r_out_data;
    hsed_pkg::t_check  r_out_check;
    logic              r_out_corrected;

    logic              s1_advance;
    logic              req_take;

    hsed_pkg::t_check  n_checks;
    hsed_pkg::t_check  n_syndrome;
    hsed_pkg::t_data   n_match;
    hsed_pkg::t_data   n_flip;
    hsed_pkg::t_data   n_data;
    hsed_pkg::t_check  n_check;
    logic              n_corrected;

    assign s1_advance  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_s1_valid || s1_advance;
    assign req_take    = i_req.valid && i_req.ready;

    // parity matrix rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < hsed_pkg::NUM_ROWS; r++) begin
                r_rows[r] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_index < hsed_pkg::CFG_IDX_W'(hsed_pkg::NUM_ROWS))) begin
            r_rows[i_cfg_index] <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_s1_action <= i_req.action;
            r_s1_data   <= i_req.data_bits & hsed_pkg::DATA_MASK;
            r_s1_check  <= i_req.check_bits & hsed_pkg::CHECK_MASK;
        end
    end

    // check bits, syndrome and column match
    always_comb begin
        n_checks = '0;
        for (int r = 0; r < hsed_pkg::NUM_ROWS; r++) begin
            n_checks[r] = ^(r_rows[r] & r_s1_data);
        end
        n_checks   = n_checks & hsed_pkg::CHECK_MASK;
        n_syndrome = (n_checks ^ r_s1_check) & hsed_pkg::CHECK_MASK;

        n_match = '0;
        for (int j = 0; j < hsed_pkg::DATA_W; j++) begin
            hsed_pkg::t_check col;
            col = '0;
            for (int r = 0; r < hsed_pkg::NUM_ROWS; r++) begin
                col[r] = r_rows[r][j];
            end
            n_match[j] = ((col & hsed_pkg::CHECK_MASK) == n_syndrome)
                         && (n_syndrome != '0) && hsed_pkg::DATA_MASK[j];
        end
        // lowest matching column wins
        n_flip = n_match & (~n_match + hsed_pkg::DATA_W'(1));

        unique case (r_s1_action)
            hsed_pkg::ACT_DECODE: begin
                n_data      = r_s1_data ^ n_flip;
                n_check     = n_syndrome;
                n_corrected = |n_match;
            end
            default: begin
                n_data      = r_s1_data;
                n_check     = n_checks;
                n_corrected = 1'b0;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_valid) begin
            r_out_data      <= n_data;
            r_out_check     <= n_check;
            r_out_corrected <= n_corrected;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.data_out  = r_out_data;
    assign o_rsp.check_out = r_out_check;
    assign o_rsp.corrected = r_out_corrected;

endmodule

>>> rtl/core/hsed_checker.sv
// checker: port-level assertions for the encode/decode unit, bound to the top level
module hsed_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_req_valid,
    input logic                    i_req_ready,
    input logic                    i_rsp_valid,
    input logic                    i_rsp_ready,
    input hsed_pkg::t_data         i_rsp_data,
    input hsed_pkg::t_check        i_rsp_check,
    input logic                    i_rsp_corrected
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_data)
            && $stable(i_rsp_check) && $stable(i_rsp_corrected)))
        else $error("result changed while stalled");

    // a correction needs a nonzero syndrome
    a_corr_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_corrected) |-> (i_rsp_check != '0))
        else $error("correction with zero syndrome");

    // nothing comes out straight after reset
    a_rst_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_rsp_valid)
        else $error("result valid after reset");

    // every accepted request shows up as a valid result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |-> ##2 i_rsp_valid)
        else $error("request did not reach the result register");

endmodule

bind hamming_sec_encode_decode_unit hsed_checker u_hsed_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_data      (o_rsp.data_out),
    .i_rsp_check     (o_rsp.check_out),
    .i_rsp_corrected (o_rsp.corrected)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// testbench: hamming sec encode/decode unit against a behavioural predictor under random stalls
module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    typedef enum logic [hsed_pkg::CFG_IDX_W-1:0] {
        REG_PARITY_ROW_0 = 3'd0,
        REG_PARITY_ROW_1 = 3'd1,
        REG_PARITY_ROW_2 = 3'd2,
        REG_PARITY_ROW_3 = 3'd3,
        REG_PARITY_ROW_4 = 3'd4,
        REG_PARITY_ROW_5 = 3'd5,
        REG_UNUSED_6     = 3'd6,
        REG_UNUSED_7     = 3'd7
    } t_reg_idx;

    typedef enum int {
        IDLE_SENDER_LIGHT,
        IDLE_SENDER_HEAVY,
        IDLE_NONE
    } t_idle_mode;

    typedef struct packed {
        hsed_pkg::t_action action;
        hsed_pkg::t_data   data_bits;
        hsed_pkg::t_check  check_bits;
    } t_req_item;

    typedef struct packed {
        hsed_pkg::t_data  data_out;
        hsed_pkg::t_check check_out;
        logic             corrected;
    } t_rsp_item;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [hsed_pkg::CFG_IDX_W-1:0] i_cfg_index;
    hsed_pkg::t_row i_cfg_wdata;

    hsed_req_if req_ch ();
    hsed_rsp_if rsp_ch ();

    hamming_sec_encode_decode_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    hsed_pkg::t_row parity_rows [hsed_pkg::NUM_ROWS];
    t_req_item  pending_reqs [$];
    t_rsp_item  expected_words [$];
    t_req_item  driven_req;
    t_idle_mode idle_mode = IDLE_SENDER_LIGHT;
    int         sender_idle_pct;
    int         receiver_idle_pct;
    int         error_count = 0;
    int         cycle_count = 0;
    int         hold_left;
    logic       hold_req = 1'b0;
    logic       hold_done;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always_comb begin
        case (idle_mode)
            IDLE_SENDER_LIGHT: begin
                sender_idle_pct   = 11;
                receiver_idle_pct = 72;
            end
            IDLE_SENDER_HEAVY: begin
                sender_idle_pct   = 72;
                receiver_idle_pct = 11;
            end
            default: begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
        endcase
    end

    function automatic hsed_pkg::t_check parity_checks(hsed_pkg::t_data d);
        hsed_pkg::t_check c;
        c = '0;
        for (int r = 0; r < hsed_pkg::CHECK_BITS; r++) begin
            c[r] = ^(parity_rows[r] & d);
        end
        return c & hsed_pkg::CHECK_MASK;
    endfunction

    function automatic t_rsp_item hamming_result(t_req_item it);
        t_rsp_item        res;
        hsed_pkg::t_data  d;
        hsed_pkg::t_check syn;
        hsed_pkg::t_check col;
        logic             hit;
        d   = it.data_bits & hsed_pkg::DATA_MASK;
        hit = 1'b0;
        if (it.action == hsed_pkg::ACT_ENCODE) begin
            res.check_out = parity_checks(d);
        end else begin
            syn = (parity_checks(d) ^ it.check_bits) & hsed_pkg::CHECK_MASK;
            res.check_out = syn;
            if (syn != '0) begin
                for (int j = 0; j < hsed_pkg::DATA_BITS; j++) begin
                    col = '0;
                    for (int r = 0; r < hsed_pkg::CHECK_BITS; r++) begin
                        col[r] = parity_rows[r][j];
                    end
                    if (!hit && col == syn) begin
                        d[j] = ~d[j];
                        hit  = 1'b1;
                    end
                end
            end
        end
        res.data_out  = d;
        res.corrected = hit;
        return res;
    endfunction

    function automatic void push_req(hsed_pkg::t_action act, hsed_pkg::t_data d,
                                     hsed_pkg::t_check c);
        t_req_item it;
        it.action     = act;
        it.data_bits  = d;
        it.check_bits = c;
        pending_reqs.insert(pending_reqs.size(), it);
    endfunction

    // mostly codewords with none, one or two errors; the rest encodes and noise
    function automatic t_req_item random_req();
        t_req_item it;
        int        kind;
        int        pick;
        int        k;
        it.action     = hsed_pkg::ACT_DECODE;
        it.data_bits  = $urandom();
        it.check_bits = hsed_pkg::t_check'($urandom());
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            it.action = hsed_pkg::ACT_ENCODE;
        end else if (kind < 85) begin
            it.check_bits = parity_checks(it.data_bits & hsed_pkg::DATA_MASK);
            pick = $urandom_range(0, 9);
            if (pick >= 2 && pick <= 7) begin
                k = $urandom_range(0, hsed_pkg::DATA_BITS - 1);
                it.data_bits[k] = ~it.data_bits[k];
            end else if (pick == 8) begin
                k = $urandom_range(0, hsed_pkg::CHECK_BITS - 1);
                it.check_bits[k] = ~it.check_bits[k];
            end else if (pick == 9) begin
                k = $urandom_range(0, hsed_pkg::DATA_BITS - 1);
                it.data_bits[k] = ~it.data_bits[k];
                k = $urandom_range(0, hsed_pkg::CHECK_BITS - 1);
                it.check_bits[k] = ~it.check_bits[k];
            end
        end
        return it;
    endfunction

    task automatic write_reg(t_reg_idx idx, hsed_pkg::t_row value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        if (idx < hsed_pkg::NUM_ROWS) begin
            parity_rows[idx] = value;
        end
    endtask

    task automatic write_matrix(hsed_pkg::t_row rows [hsed_pkg::NUM_ROWS]);
        for (int r = 0; r < hsed_pkg::NUM_ROWS; r++) begin
            write_reg(t_reg_idx'(r), rows[r]);
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained(int settle);
        do begin
            @(negedge i_clk);
        end while (pending_reqs.size() != 0 || req_ch.valid || expected_words.size() != 0);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) begin
            pending_reqs.insert(pending_reqs.size(), random_req());
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_words.insert(expected_words.size(), hamming_result(driven_req));
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    driven_req = pending_reqs.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.action     <= driven_req.action;
                    req_ch.data_bits  <= driven_req.data_bits;
                    req_ch.check_bits <= driven_req.check_bits;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_rsp_item want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual data %h check %h corrected %b",
                             $time, rsp_ch.data_out, rsp_ch.check_out, rsp_ch.corrected);
                    error_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (rsp_ch.data_out !== want.data_out) begin
                        $display("%0t: data_out mismatch, expected %h, actual %h",
                                 $time, want.data_out, rsp_ch.data_out);
                        error_count++;
                    end
                    if (rsp_ch.check_out !== want.check_out) begin
                        $display("%0t: check_out mismatch, expected %h, actual %h",
                                 $time, want.check_out, rsp_ch.check_out);
                        error_count++;
                    end
                    if (rsp_ch.corrected !== want.corrected) begin
                        $display("%0t: corrected mismatch, expected %b, actual %b",
                                 $time, want.corrected, rsp_ch.corrected);
                        error_count++;
                    end
                end
            end
            rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        hsed_pkg::t_row   rows [hsed_pkg::NUM_ROWS];
        hsed_pkg::t_check v;
        int               j;
        hsed_pkg::t_data  d;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = '0;
        i_cfg_wdata       = '0;
        req_ch.valid      = 1'b0;
        req_ch.action     = hsed_pkg::ACT_ENCODE;
        req_ch.data_bits  = '0;
        req_ch.check_bits = '0;
        rsp_ch.ready      = 1'b0;
        for (int r = 0; r < hsed_pkg::NUM_ROWS; r++) begin
            parity_rows[r] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all-zero matrix out of reset
        push_req(hsed_pkg::ACT_ENCODE, '0, '0);
        push_req(hsed_pkg::ACT_ENCODE, '1, '1);
        push_req(hsed_pkg::ACT_DECODE, '1, '1);
        push_req(hsed_pkg::ACT_DECODE, 32'h1234_5678, '0);
        wait_drained(4);

        // standard matrix: distinct columns of weight two or more
        for (int r = 0; r < hsed_pkg::NUM_ROWS; r++) begin
            rows[r] = '0;
        end
        j = 0;
        for (int c = 3; c < 64 && j < hsed_pkg::DATA_BITS; c++) begin
            v = hsed_pkg::t_check'(c);
            if ($countones(v) >= 2) begin
                for (int r = 0; r < hsed_pkg::NUM_ROWS; r++) begin
                    rows[r][j] = v[r];
                end
                j++;
            end
        end
        write_reg(REG_UNUSED_6, '1);
        write_reg(REG_UNUSED_7, 32'hDEAD_BEEF);
        write_matrix(rows);
        d = 32'hA5A5_A5A5;
        push_req(hsed_pkg::ACT_ENCODE, '0, '1);
        push_req(hsed_pkg::ACT_ENCODE, '1, '0);
        push_req(hsed_pkg::ACT_ENCODE, d, '0);
        push_req(hsed_pkg::ACT_DECODE, d, parity_checks(d));
        push_req(hsed_pkg::ACT_DECODE, d ^ 32'h0000_0001, parity_checks(d));
        push_req(hsed_pkg::ACT_DECODE, d ^ 32'h8000_0000, parity_checks(d));
        push_req(hsed_pkg::ACT_DECODE, d, parity_checks(d) ^ 6'h20);
        push_req(hsed_pkg::ACT_DECODE, '0, 6'h3F);
        push_req(hsed_pkg::ACT_DECODE, '1, '1);
        wait_drained(4);

        // every column equal: lowest data bit wins
        for (int r = 0; r < hsed_pkg::NUM_ROWS; r++) begin
            rows[r] = '1;
        end
        write_matrix(rows);
        push_req(hsed_pkg::ACT_DECODE, '0, 6'h3F);
        push_req(hsed_pkg::ACT_ENCODE, '1, '0);
        push_req(hsed_pkg::ACT_ENCODE, 32'h0000_0001, '0);
        wait_drained(4);

        // unit-vector columns in the data part of P
        for (int r = 0; r < hsed_pkg::NUM_ROWS; r++) begin
            rows[r] = '0;
        end
        rows[0] = 32'h0000_0001;
        rows[1] = 32'h8000_0000;
        write_matrix(rows);
        push_req(hsed_pkg::ACT_DECODE, '0, 6'h01);
        push_req(hsed_pkg::ACT_DECODE, '0, 6'h02);
        push_req(hsed_pkg::ACT_DECODE, '0, 6'h04);
        wait_drained(4);

        // random matrix, light sender idling
        for (int r = 0; r < hsed_pkg::NUM_ROWS; r++) begin
            rows[r] = $urandom();
        end
        write_matrix(rows);
        queue_random(130);
        wait_drained(4);

        // standard-style matrix again with heavy sender idling
        idle_mode = IDLE_SENDER_HEAVY;
        for (int r = 0; r < hsed_pkg::NUM_ROWS; r++) begin
            rows[r] = '0;
        end
        j = 0;
        for (int c = 63; c > 2 && j < hsed_pkg::DATA_BITS; c--) begin
            v = hsed_pkg::t_check'(c);
            if ($countones(v) >= 2) begin
                for (int r = 0; r < hsed_pkg::NUM_ROWS; r++) begin
                    rows[r][j] = v[r];
                end
                j++;
            end
        end
        write_matrix(rows);
        queue_random(130);
        wait_drained(4);

        // no idling, receiver stalled long enough to back up the input
        idle_mode = IDLE_NONE;
        for (int r = 0; r < hsed_pkg::NUM_ROWS; r++) begin
            rows[r] = $urandom();
        end
        write_matrix(rows);
        queue_random(140);
        @(negedge i_clk);
        hold_req = 1'b1;
        wait_drained(10);

        if (error_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
